/* src/bltc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the button LED timeout controller.
// No dependencies; imported by button_led_timeout_controller_core.
package bltc_pkg;

  localparam int NumButtons = 5;
  localparam int BtnW       = 3;
  localparam int ColorW     = 24;
  localparam int CountW     = 16;
  localparam int ColorsW    = 2 * ColorW;
  localparam int ApbDataW   = 64;
  localparam int ApbAddrW   = 6;
  localparam int RegIdxW    = 3;

  // a gesture or downlink gives at most two writes, a tick one per button
  localparam int MaxResults = (NumButtons > 2) ? NumButtons : 2;
  localparam int ResIdxW    = $clog2(MaxResults);
  localparam int ResCntW    = $clog2(MaxResults + 1);

  // register map, 8-byte stride
  localparam logic [RegIdxW-1:0] RegSingleMode   = 3'd0;
  localparam logic [RegIdxW-1:0] RegDispTimeout  = 3'd1;
  localparam logic [RegIdxW-1:0] RegColorsBase   = 3'd2;

  typedef enum logic [1:0] {
    ACT_GESTURE  = 2'd0,
    ACT_DOWNLINK = 2'd1,
    ACT_TICK     = 2'd2
  } action_e;

  typedef struct packed {
    logic [BtnW-1:0]   btn;
    logic [ColorW-1:0] rgb;
  } led_write_t;

  // per-channel maximum of two 0xRRGGBB values
  function automatic logic [ColorW-1:0] chan_max(input logic [ColorW-1:0] a,
                                                 input logic [ColorW-1:0] b);
    logic [ColorW-1:0] r;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      r[c*8 +: 8] = (a[c*8 +: 8] > b[c*8 +: 8]) ? a[c*8 +: 8] : b[c*8 +: 8];
    end
    return r;
  endfunction

endpackage

/* src/button_led_timeout_controller_core.sv */
`timescale 1ns / 1ps
// Button LED timeout controller: slot state, APB registers, result queue.
// Depends on bltc_pkg.
//
// Usage:
//   s_axis carries one command per transfer: a button gesture, a downlink
//   colour set or a one-second tick. m_axis carries LED writes (button index
//   and RGB); tlast marks the final write caused by a command. Gestures and
//   downlinks with an out-of-range button, the unused action code, or a tick
//   with no expiry give no write at all.
//   All state is updated in the accept cycle; the writes of that command go to
//   a small result queue and then, one per cycle unless m_axis stalls, to the
//   output register. A command holds the queue until its writes (one or two
//   for a gesture or downlink, up to five for a tick) have moved on; the next
//   command is taken as its last write moves on, so commands with at most one
//   write run at one per cycle unless m_axis stalls; the queue drain sets the
//   rate. The user must write the APB port (8-byte register stride) only
//   while idle; the block itself does not enforce this. pready is tied high.
//   Reset clears registers, slots and the lit-button record, and empties the
//   queue. When m_axis stalls the output register holds; s_axis is ready
//   only while the queue is empty or its last write moves on.
module button_led_timeout_controller_core
  import bltc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // command stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // button[2:0], packed_color[26:3]
  input  logic [2:0]          s_axis_tuser,  // action[1:0], is_hold[2]
  // LED write stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // led_btn[2:0], red[10:3],
                                             // green[18:11], blue[26:19]
  output logic                m_axis_tlast
);

  // configuration
  logic                single_mode_q;
  logic [CountW-1:0]   disp_to_q;
  logic [ColorsW-1:0]  colors_q [NumButtons];
  logic [RegIdxW-1:0]  reg_idx;
  logic                cfg_wr;

  // slot state
  logic [ColorW-1:0]   click_col_q [NumButtons];
  logic [ColorW-1:0]   click_col_d [NumButtons];
  logic [ColorW-1:0]   hold_col_q  [NumButtons];
  logic [ColorW-1:0]   hold_col_d  [NumButtons];
  logic [CountW-1:0]   click_cd_q  [NumButtons];
  logic [CountW-1:0]   click_cd_d  [NumButtons];
  logic [CountW-1:0]   hold_cd_q   [NumButtons];
  logic [CountW-1:0]   hold_cd_d   [NumButtons];
  logic                lit_known_q, lit_known_d;
  logic [BtnW-1:0]     lit_btn_q,   lit_btn_d;

  // result queue and output register
  led_write_t          pend_q [MaxResults];
  led_write_t          res_d  [MaxResults];
  logic [ResCntW-1:0]  res_n;
  logic [ResCntW-1:0]  pend_cnt_q;
  logic [ResCntW-1:0]  pend_rd_q;
  logic                pend_has, last_one, out_load, in_fire;
  logic                out_valid_q;
  logic                out_last_q;
  led_write_t          out_q;

  // command decode
  action_e             act;
  logic                is_hold;
  logic [BtnW-1:0]     btn;
  logic [ColorW-1:0]   packed_col;

  assign act        = action_e'(s_axis_tuser[1:0]);
  assign is_hold    = s_axis_tuser[2];
  assign btn        = s_axis_tdata[2:0];
  assign packed_col = s_axis_tdata[26:3];

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_mode_q <= 1'b0;
      disp_to_q     <= '0;
      for (int b = 0; b < NumButtons; b++) begin
        colors_q[b] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx == RegSingleMode) begin
        single_mode_q <= pwdata[0];
      end
      if (reg_idx == RegDispTimeout) begin
        disp_to_q <= pwdata[CountW-1:0];
      end
      for (int b = 0; b < NumButtons; b++) begin
        if (reg_idx == RegColorsBase + RegIdxW'(b)) begin
          colors_q[b] <= pwdata[ColorsW-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegSingleMode) begin
      prdata = ApbDataW'(single_mode_q);
    end else if (reg_idx == RegDispTimeout) begin
      prdata = ApbDataW'(disp_to_q);
    end
    for (int b = 0; b < NumButtons; b++) begin
      if (reg_idx == RegColorsBase + RegIdxW'(b)) begin
        prdata = ApbDataW'(colors_q[b]);
      end
    end
  end

  // ---------------------------------------------------------------- handshake
  assign pend_has      = (pend_rd_q != pend_cnt_q);
  assign last_one      = (ResCntW'(pend_rd_q + 1'b1) == pend_cnt_q);
  assign out_load      = pend_has && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_has || (last_one && out_load);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- command
  always_comb begin
    logic [ColorsW-1:0] sel_colors;
    logic [ColorW-1:0]  sel_click, sel_hold, gest_col, new_col, other_col;
    logic               btn_ok, expired;

    sel_colors = '0;
    sel_click  = '0;
    sel_hold   = '0;
    for (int b = 0; b < NumButtons; b++) begin
      if (btn == BtnW'(b)) begin
        sel_colors = colors_q[b];
        sel_click  = click_col_q[b];
        sel_hold   = hold_col_q[b];
      end
    end
    btn_ok    = (btn < BtnW'(NumButtons));
    gest_col  = is_hold ? sel_colors[ColorsW-1:ColorW] : sel_colors[ColorW-1:0];
    other_col = is_hold ? sel_click : sel_hold;
    new_col   = (act == ACT_GESTURE) ? gest_col : packed_col;
    expired   = 1'b0;

    click_col_d = click_col_q;
    hold_col_d  = hold_col_q;
    click_cd_d  = click_cd_q;
    hold_cd_d   = hold_cd_q;
    lit_known_d = lit_known_q;
    lit_btn_d   = lit_btn_q;
    res_n       = '0;
    for (int j = 0; j < MaxResults; j++) begin
      res_d[j] = '0;
    end

    case (act)
      ACT_GESTURE, ACT_DOWNLINK: begin
        if (btn_ok) begin
          // single mode: a lit colour blanks the previously lit button first
          if (single_mode_q && new_col != '0) begin
            if (lit_known_q && lit_btn_q != btn) begin
              for (int b = 0; b < NumButtons; b++) begin
                if (lit_btn_q == BtnW'(b)) begin
                  click_col_d[b] = '0;
                  hold_col_d[b]  = '0;
                  click_cd_d[b]  = '0;
                  hold_cd_d[b]   = '0;
                end
              end
              res_d[0] = '{btn: lit_btn_q, rgb: '0};
              res_n    = ResCntW'(1);
            end
            lit_btn_d   = btn;
            lit_known_d = 1'b1;
          end
          res_d[res_n[ResIdxW-1:0]].btn = btn;
          if (act == ACT_GESTURE) begin
            res_d[res_n[ResIdxW-1:0]].rgb = chan_max(gest_col, other_col);
          end else begin
            res_d[res_n[ResIdxW-1:0]].rgb = packed_col;
          end
          res_n = ResCntW'(res_n + 1'b1);
          for (int b = 0; b < NumButtons; b++) begin
            if (btn == BtnW'(b)) begin
              if (act == ACT_DOWNLINK) begin
                click_col_d[b] = '0;
                hold_col_d[b]  = '0;
                click_cd_d[b]  = '0;
                hold_cd_d[b]   = '0;
              end else if (is_hold) begin
                hold_col_d[b] = gest_col;
                hold_cd_d[b]  = disp_to_q;
              end else begin
                click_col_d[b] = gest_col;
                click_cd_d[b]  = disp_to_q;
              end
            end
          end
        end
      end
      ACT_TICK: begin
        for (int b = 0; b < NumButtons; b++) begin
          expired = 1'b0;
          if (click_cd_q[b] != '0) begin
            click_cd_d[b] = CountW'(click_cd_q[b] - 1'b1);
            if (click_cd_q[b] == CountW'(1)) begin
              click_col_d[b] = '0;
              expired        = 1'b1;
            end
          end
          if (hold_cd_q[b] != '0) begin
            hold_cd_d[b] = CountW'(hold_cd_q[b] - 1'b1);
            if (hold_cd_q[b] == CountW'(1)) begin
              hold_col_d[b] = '0;
              expired       = 1'b1;
            end
          end
          if (expired) begin
            res_d[res_n[ResIdxW-1:0]].btn = BtnW'(b);
            res_d[res_n[ResIdxW-1:0]].rgb = chan_max(click_col_d[b], hold_col_d[b]);
            res_n = ResCntW'(res_n + 1'b1);
          end
        end
      end
      default: begin
        // unused action code: no state change, no write
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_known_q <= 1'b0;
      lit_btn_q   <= '0;
      for (int b = 0; b < NumButtons; b++) begin
        click_col_q[b] <= '0;
        hold_col_q[b]  <= '0;
        click_cd_q[b]  <= '0;
        hold_cd_q[b]   <= '0;
      end
    end else if (in_fire) begin
      lit_known_q <= lit_known_d;
      lit_btn_q   <= lit_btn_d;
      click_col_q <= click_col_d;
      hold_col_q  <= hold_col_d;
      click_cd_q  <= click_cd_d;
      hold_cd_q   <= hold_cd_d;
    end
  end

  // ---------------------------------------------------------------- queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= '0;
      pend_rd_q  <= '0;
    end else if (in_fire) begin
      pend_cnt_q <= res_n;
      pend_rd_q  <= '0;
    end else if (out_load) begin
      pend_rd_q  <= ResCntW'(pend_rd_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q      <= pend_q[pend_rd_q[ResIdxW-1:0]];
      out_last_q <= last_one;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_q.rgb[7:0], out_q.rgb[15:8], out_q.rgb[23:16],
                          out_q.btn};

`ifndef SYNTH
  a_rd_le_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_rd_q <= pend_cnt_q)
    else $error("result queue read pointer passed fill count");

  a_cnt_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= ResCntW'(MaxResults))
    else $error("result queue overfilled");

  a_lit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_known_q |-> (lit_btn_q < BtnW'(NumButtons)))
    else $error("lit button out of range");

  a_burst_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("gap inside the writes of one command");
`endif

endmodule

/* tb/sv/bltc_led_checker.sv */
`timescale 1ns / 1ps
// LED write checker for button_led_timeout_controller_core: follows APB writes and
// command transfers, predicts the LED writes and compares them with m_axis.
// Depends on bltc_pkg.
module bltc_led_checker
  import bltc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // button[2:0], packed_color[26:3]
  input  logic [2:0]          s_axis_tuser,  // action[1:0], is_hold[2]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [31:0]         m_axis_tdata,  // led_btn[2:0], red[10:3],
                                             // green[18:11], blue[26:19]
  input  logic                m_axis_tlast,
  output int                  fails_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [BtnW-1:0] btn;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic            last;
  } led_exp_t;

  led_exp_t            led_q[$];
  int                  fails = 0;
  int                  pending = 0;

  logic                single_mode;
  logic [CountW-1:0]   disp_timeout;
  logic [ColorsW-1:0]  btn_colors [NumButtons];
  logic [ColorW-1:0]   slot_rgb   [2*NumButtons];
  logic [CountW-1:0]   slot_secs  [2*NumButtons];
  logic                lit_valid;
  logic [BtnW-1:0]     lit_btn;

  assign fails_o   = fails;
  assign pending_o = pending;

  // brightest of click and hold, channel by channel
  function automatic logic [ColorW-1:0] shown_rgb(input int b);
    logic [ColorW-1:0] c;
    logic [ColorW-1:0] h;
    logic [ColorW-1:0] r;
    c = slot_rgb[2*b];
    h = slot_rgb[2*b + 1];
    for (int ch = 0; ch < 3; ch++) begin
      r[ch*8 +: 8] = (c[ch*8 +: 8] > h[ch*8 +: 8]) ? c[ch*8 +: 8] : h[ch*8 +: 8];
    end
    return r;
  endfunction

  function automatic void push_led(input int b, input logic [ColorW-1:0] rgb);
    led_exp_t e;
    e.btn   = b[BtnW-1:0];
    e.red   = rgb[23:16];
    e.green = rgb[15:8];
    e.blue  = rgb[7:0];
    e.last  = 1'b0;
    led_q.push_back(e);
  endfunction

  function automatic void clear_button(input int b);
    for (int k = 0; k < 2; k++) begin
      slot_rgb[2*b + k]  = '0;
      slot_secs[2*b + k] = '0;
    end
  endfunction

  // single mode: the button lit before goes dark first
  function automatic void blank_other(input logic [BtnW-1:0] b);
    if (lit_valid && lit_btn != b && lit_btn < NumButtons) begin
      clear_button(int'(lit_btn));
      push_led(int'(lit_btn), shown_rgb(int'(lit_btn)));
    end
    lit_btn   = b;
    lit_valid = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    led_exp_t          want;
    led_exp_t          tail;
    logic [1:0]        act;
    logic [BtnW-1:0]   btn;
    logic              hold;
    logic [ColorW-1:0] rgb;
    logic [2:0]        reg_idx;
    logic              expired;
    int                n0;
    if (!rst_ni) begin
      single_mode  = 1'b0;
      disp_timeout = '0;
      for (int i = 0; i < NumButtons; i++) begin
        btn_colors[i] = '0;
        clear_button(i);
      end
      lit_valid = 1'b0;
      lit_btn   = '0;
      led_q.delete();
    end else begin
      // outputs first: nothing accepted at this edge can show up yet
      if (m_axis_tvalid && m_axis_tready) begin
        if (led_q.size() == 0) begin
          $error("unexpected LED write: led_btn %0d rgb %06h last %0b",
                 m_axis_tdata[2:0], {m_axis_tdata[10:3], m_axis_tdata[18:11],
                 m_axis_tdata[26:19]}, m_axis_tlast);
          fails++;
        end else begin
          want = led_q.pop_front();
          if (m_axis_tdata[2:0] !== want.btn) begin
            $error("led_btn: expected %0d, got %0d", want.btn, m_axis_tdata[2:0]);
            fails++;
          end
          if (m_axis_tdata[10:3] !== want.red) begin
            $error("red: expected %02h, got %02h", want.red, m_axis_tdata[10:3]);
            fails++;
          end
          if (m_axis_tdata[18:11] !== want.green) begin
            $error("green: expected %02h, got %02h", want.green, m_axis_tdata[18:11]);
            fails++;
          end
          if (m_axis_tdata[26:19] !== want.blue) begin
            $error("blue: expected %02h, got %02h", want.blue, m_axis_tdata[26:19]);
            fails++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            fails++;
          end
        end
      end

      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[ApbAddrW-1:3];
        if (reg_idx == RegSingleMode) begin
          single_mode = pwdata[0];
        end else if (reg_idx == RegDispTimeout) begin
          disp_timeout = pwdata[CountW-1:0];
        end else if (reg_idx >= RegColorsBase && reg_idx < RegColorsBase + NumButtons) begin
          btn_colors[reg_idx - RegColorsBase] = pwdata[ColorsW-1:0];
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        act  = s_axis_tuser[1:0];
        hold = s_axis_tuser[2];
        btn  = s_axis_tdata[2:0];
        rgb  = s_axis_tdata[26:3];
        n0   = led_q.size();
        case (act)
          ACT_GESTURE: begin
            if (btn < NumButtons) begin
              rgb = hold ? btn_colors[btn][ColorsW-1:ColorW] : btn_colors[btn][ColorW-1:0];
              // a gesture with no colour still arms its slot but blanks nothing
              if (single_mode && rgb != '0) blank_other(btn);
              slot_rgb[2*btn + hold]  = rgb;
              slot_secs[2*btn + hold] = disp_timeout;
              push_led(int'(btn), shown_rgb(int'(btn)));
            end
          end
          ACT_DOWNLINK: begin
            if (btn < NumButtons) begin
              if (single_mode && rgb != '0) blank_other(btn);
              push_led(int'(btn), rgb);
              clear_button(int'(btn));
            end
          end
          ACT_TICK: begin
            for (int b = 0; b < NumButtons; b++) begin
              expired = 1'b0;
              for (int k = 0; k < 2; k++) begin
                if (slot_secs[2*b + k] != '0) begin
                  slot_secs[2*b + k] = slot_secs[2*b + k] - 1'b1;
                  if (slot_secs[2*b + k] == '0) begin
                    slot_rgb[2*b + k] = '0;
                    expired = 1'b1;
                  end
                end
              end
              if (expired) push_led(b, shown_rgb(b));
            end
          end
          default: ;
        endcase
        if (led_q.size() > n0) begin
          tail      = led_q.pop_back();
          tail.last = 1'b1;
          led_q.push_back(tail);
        end
      end
    end
    pending = led_q.size();
  end

endmodule

/* tb/sv/tb_button_led_timeout_controller_core.sv */
`timescale 1ns / 1ps
// Testbench top for button_led_timeout_controller_core: clock, reset, APB set-up,
// command stimulus and LED write back-pressure. Needs bltc_pkg and bltc_led_checker.
module tb_button_led_timeout_controller_core;
  import bltc_pkg::*;

  localparam int         ClkPeriod   = 20;
  localparam int         LimitCycles = 500_000;
  localparam int         PhaseItems  = 47;
  localparam int         Phases      = 8;
  localparam int         DrainCycles = 8;
  localparam int         LongHold    = 400;
  localparam logic [1:0] ActUnused   = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // button[2:0], packed_color[26:3]
  logic [2:0]          s_axis_tuser  = '0;  // action[1:0], is_hold[2]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;        // led_btn[2:0], red[10:3],
                                            // green[18:11], blue[26:19]
  logic                m_axis_tlast;

  int led_fails;
  int leds_owed;
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit long_hold_req = 1'b0;

  button_led_timeout_controller_core dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  bltc_led_checker checker_i (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fails_o   (led_fails),
    .pending_o (leds_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("tb_button_led_timeout_controller_core failed");
    $finish;
  end

  task automatic apb_write(input logic [2:0] idx, input logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // returns at the edge where the command transfer takes place
  task automatic send_cmd(input logic [1:0] act, input logic [2:0] btn, input logic hold,
                          input logic [23:0] rgb);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, rgb, btn};
    s_axis_tuser  <= {hold, act};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  // quiet the command side, let every owed write out, then allow for
  // commands that cause no write but may still be in flight
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (leds_owed != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // LED write side: random stalls, one long hold-off on request
  initial begin
    int stall_cycles;
    bit long_hold_done;
    long_hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_cycles   = LongHold;
      end else begin
        stall_cycles = rx_quiet ? 0 : $urandom_range(0, 12);
      end
      if (stall_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      @(posedge clk_i);
    end
  end

  initial begin
    int               counted;
    int               sel;
    logic [1:0]       act;
    logic [2:0]       btn;
    logic             hold;
    logic [23:0]      rgb;
    logic [47:0]      cols;
    logic [15:0]      secs;
    logic             single;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all colours zero, no timeout
    send_cmd(ACT_GESTURE, 3'd0, 1'b0, 24'h000000);
    send_cmd(ActUnused, 3'd2, 1'b1, 24'hFFFFFF);
    send_cmd(ACT_GESTURE, 3'd5, 1'b1, 24'h000000);
    send_cmd(ACT_DOWNLINK, 3'd7, 1'b0, 24'hFFFFFF);
    send_cmd(ACT_TICK, 3'd0, 1'b0, 24'h000000);
    wait_idle();

    // single mode with a short timeout
    apb_write(RegSingleMode, 64'd1);
    apb_write(RegDispTimeout, 64'd2);
    apb_write(RegColorsBase + 3'd0, 64'h0000_FFFFFF_000000);
    apb_write(RegColorsBase + 3'd1, 64'h0000_123456_ABCDEF);
    apb_write(RegColorsBase + 3'd2, 64'h0000_FFFFFF_FFFFFF);
    apb_write(RegColorsBase + 3'd3, 64'h0000_00FF00_FF0000);
    apb_write(RegColorsBase + 3'd4, 64'h0000_804020_010204);
    send_cmd(ACT_GESTURE, 3'd1, 1'b0, 24'h000000);
    send_cmd(ACT_GESTURE, 3'd3, 1'b1, 24'h000000);   // blanks button 1
    send_cmd(ACT_GESTURE, 3'd0, 1'b0, 24'h000000);   // colourless, no blanking
    send_cmd(ACT_GESTURE, 3'd3, 1'b0, 24'h000000);   // same button, max of slots
    send_cmd(ACT_DOWNLINK, 3'd2, 1'b0, 24'hFFFFFF);  // blanks button 3
    send_cmd(ACT_DOWNLINK, 3'd4, 1'b1, 24'h000000);  // off, no blanking
    send_cmd(ACT_DOWNLINK, 3'd7, 1'b0, 24'h123456);
    send_cmd(ACT_GESTURE, 3'd6, 1'b1, 24'h000000);
    send_cmd(ACT_TICK, 3'd0, 1'b0, 24'h000000);
    send_cmd(ACT_TICK, 3'd0, 1'b0, 24'h000000);      // button 0 click slot expires
    send_cmd(ACT_GESTURE, 3'd4, 1'b1, 24'h000000);
    send_cmd(ACT_GESTURE, 3'd0, 1'b1, 24'h000000);
    wait_idle();

    // every button expires on the same tick
    apb_write(RegSingleMode, 64'd0);
    apb_write(RegDispTimeout, 64'd1);
    for (int b = 0; b < NumButtons; b++) begin
      send_cmd(ACT_GESTURE, b[2:0], b[0], 24'h000000);
    end
    send_cmd(ACT_TICK, 3'd0, 1'b0, 24'h000000);
    wait_idle();

    for (int p = 0; p < Phases; p++) begin
      single = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      if (p == 1) secs = 16'hFFFF;
      else if (p == 4) secs = 16'h0000;
      else if (p == 6) secs = 16'($urandom_range(0, 16'hFFFF));
      else secs = 16'($urandom_range(1, 5));
      apb_write(RegSingleMode, {63'd0, single});
      apb_write(RegDispTimeout, {48'd0, secs});
      for (int b = 0; b < NumButtons; b++) begin
        cols[47:24] = 24'($urandom_range(0, 24'hFFFFFF));
        cols[23:0]  = 24'($urandom_range(0, 24'hFFFFFF));
        sel = $urandom_range(0, 7);
        if (p == 3 || sel == 1) cols = '1;
        else if (sel == 0) cols = '0;
        else if (sel == 2) cols[23:0] = '0;
        else if (sel == 3) cols[47:24] = '0;
        apb_write(RegColorsBase + b[2:0], {16'd0, cols});
      end

      // phase 2 stalls the LED side long enough to back the commands up
      tx_quiet = (p == 2 || p == 5);
      rx_quiet = (p == 5);
      if (p == 2) long_hold_req = 1'b1;

      counted = 0;
      while (counted < PhaseItems) begin
        sel  = $urandom_range(0, 99);
        btn  = 3'($urandom_range(0, NumButtons - 1));
        hold = 1'($urandom_range(0, 1));
        rgb  = 24'($urandom_range(0, 24'hFFFFFF));
        if (sel < 45) begin
          act = ACT_GESTURE;
        end else if (sel < 65) begin
          act = ACT_DOWNLINK;
          case ($urandom_range(0, 5))
            0: rgb = 24'h000000;
            1: rgb = 24'hFFFFFF;
            default: ;
          endcase
        end else if (sel < 94) begin
          act = ACT_TICK;
          btn = 3'($urandom_range(0, 7));
        end else if (sel < 97) begin
          act = ActUnused;
          btn = 3'($urandom_range(0, 7));
        end else begin
          act = $urandom_range(0, 1) ? ACT_DOWNLINK : ACT_GESTURE;
          btn = 3'($urandom_range(NumButtons, 7));
        end
        send_cmd(act, btn, hold, rgb);
        if (sel < 94) counted++;
      end
      wait_idle();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
    end

    if (led_fails == 0 && leds_owed == 0) begin
      $display("tb_button_led_timeout_controller_core passed");
    end else begin
      $display("tb_button_led_timeout_controller_core failed");
    end
    $finish;
  end

endmodule
